// File: rtl/i2cblm_pkg.sv
// ----------------------------------------------------------------------------
// i2cblm_pkg
// command codes, phase codes and field widths of the bit-level i2c master
// ----------------------------------------------------------------------------
package i2cblm_pkg;

	localparam int unsigned CmdW   = 3;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned TickW  = 10;
	localparam int unsigned PhaseW = 2;
	localparam int unsigned BitCntW = 4;

	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutDataW = 16;

	typedef logic [CmdW-1:0]    cmd_t;
	typedef logic [ByteW-1:0]   byte_t;
	typedef logic [TickW-1:0]   tick_t;
	typedef logic [PhaseW-1:0]  phase_t;
	typedef logic [BitCntW-1:0] bit_cnt_t;

	localparam cmd_t CMD_NONE  = 3'd0;
	localparam cmd_t CMD_START = 3'd1;
	localparam cmd_t CMD_STOP  = 3'd2;
	localparam cmd_t CMD_WRITE = 3'd3;
	localparam cmd_t CMD_READ  = 3'd4;
	localparam cmd_t CMD_ACK   = 3'd5;
	localparam cmd_t CMD_NACK  = 3'd6;

	// phase 1 is the scl-low half (scl stays high for start), phase 2 the scl-high half, phase 3 only for stop
	localparam phase_t PH_IDLE  = 2'd0;
	localparam phase_t PH_FIRST = 2'd1;
	localparam phase_t PH_SECOND = 2'd2;
	localparam phase_t PH_THIRD = 2'd3;

	localparam bit_cnt_t BITS_PER_BYTE = 4'd8;
	localparam tick_t    HALF_PHASE_RESET = 10'd4;

	// result word fields
	typedef struct packed {
		logic  cmd_rejected;
		logic  nack_seen;
		byte_t read_byte;
		logic  done_res;
		logic  busy_res;
		logic  sda_level;
		logic  scl_level;
	} result_t;

endpackage

// File: rtl/i2c_bit_level_master.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// bit-level i2c master sequencer stepped by one input word per bus tick
// ----------------------------------------------------------------------------
// Each input word is one tick of the bus sequencer and yields exactly one
// result word giving the scl/sda levels to drive on that tick, busy and done
// flags, the last read byte, the last acknowledge bit and a reject flag. While
// idle a cmd from 1 to 6 starts a command (start, stop, write byte, read byte, ack,
// nack) whose first phase is driven on the same tick; a cmd that arrives while
// busy is dropped and flagged. Every bus phase lasts half_phase_ticks ticks
// (zero acts as one); received bits and the ack bit are sampled from sda_in on
// the last tick of an scl-high phase. Throughput is one word per clock: the
// whole sequencer update is a single registered step from the current state
// and the accepted word into the state registers and the result register.
// A waiting result blocks the input only until it drains, and a new word is
// taken in the same cycle the waiting result leaves. The result of a word is
// valid from the cycle after that word is accepted.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave side: [2:0] cmd, [10:3] write_byte, [11] sda_in, [15:12] zero
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [i2cblm_pkg::InDataW-1:0]       s_tdata,
	// master side: [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
	// [11:4] read_byte, [12] nack_seen, [13] cmd_rejected, [15:14] zero
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [i2cblm_pkg::OutDataW-1:0]      m_tdata,
	// half_phase_ticks register
	input  logic                                 cfg_wr_en,
	input  logic [i2cblm_pkg::TickW-1:0]         cfg_wr_data
);

	// configuration
	i2cblm_pkg::tick_t half_q;

	// sequencer state
	i2cblm_pkg::phase_t   phase_q;
	i2cblm_pkg::bit_cnt_t bit_cnt_q;
	i2cblm_pkg::tick_t    tick_q;
	i2cblm_pkg::byte_t    shift_q;
	i2cblm_pkg::cmd_t     act_cmd_q;
	logic                 scl_q;
	logic                 sda_q;
	logic                 ack_q;
	i2cblm_pkg::byte_t    read_q;

	// result register
	logic                  m_tvalid_q;
	i2cblm_pkg::result_t   res_q;

	// input word fields
	i2cblm_pkg::cmd_t  in_cmd;
	i2cblm_pkg::byte_t in_wbyte;
	logic              in_sda;
	logic              accept;

	assign in_cmd   = s_tdata[2:0];
	assign in_wbyte = s_tdata[10:3];
	assign in_sda   = s_tdata[11];

	// output register frees up when empty or being drained
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// next-state logic
	i2cblm_pkg::tick_t    h_eff;
	i2cblm_pkg::phase_t   ph_a, ph_n;
	i2cblm_pkg::bit_cnt_t bc_a, bc_n;
	i2cblm_pkg::tick_t    tk_a, tk_inc, tk_n;
	i2cblm_pkg::byte_t    sh_a, sh_n;
	i2cblm_pkg::cmd_t     cmd_a;
	i2cblm_pkg::byte_t    read_n;
	logic                 lvl_scl, lvl_sda;
	logic                 scl_n, sda_n, ack_n;
	logic                 scl_out, sda_out;
	logic                 rejected, busy, done;
	i2cblm_pkg::result_t  res_n;

	always_comb begin
		h_eff = (half_q == '0) ? i2cblm_pkg::tick_t'(1) : half_q;

		// command pickup
		ph_a     = phase_q;
		bc_a     = bit_cnt_q;
		tk_a     = tick_q;
		sh_a     = shift_q;
		cmd_a    = act_cmd_q;
		rejected = 1'b0;
		if (phase_q != i2cblm_pkg::PH_IDLE) begin
			rejected = (in_cmd != i2cblm_pkg::CMD_NONE);
		end else if (in_cmd >= i2cblm_pkg::CMD_START && in_cmd <= i2cblm_pkg::CMD_NACK) begin
			cmd_a = in_cmd;
			ph_a  = i2cblm_pkg::PH_FIRST;
			tk_a  = '0;
			bc_a  = '0;
			sh_a  = (in_cmd == i2cblm_pkg::CMD_WRITE) ? in_wbyte : '0;
		end

		// bus levels of the current phase
		lvl_scl = (ph_a == i2cblm_pkg::PH_SECOND);
		lvl_sda = 1'b1;
		case (cmd_a)
			i2cblm_pkg::CMD_START: begin
				lvl_scl = 1'b1;
				lvl_sda = (ph_a == i2cblm_pkg::PH_FIRST);
			end
			i2cblm_pkg::CMD_STOP: begin
				lvl_scl = (ph_a != i2cblm_pkg::PH_FIRST);
				lvl_sda = (ph_a == i2cblm_pkg::PH_THIRD);
			end
			i2cblm_pkg::CMD_WRITE: begin
				lvl_sda = (bc_a < i2cblm_pkg::BITS_PER_BYTE) ? sh_a[7] : 1'b1;
			end
			i2cblm_pkg::CMD_ACK: begin
				lvl_sda = 1'b0;
			end
			default: begin
			end
		endcase

		ph_n   = ph_a;
		bc_n   = bc_a;
		tk_n   = tk_a;
		sh_n   = sh_a;
		scl_n  = scl_q;
		sda_n  = sda_q;
		ack_n  = ack_q;
		read_n = read_q;
		busy   = 1'b0;
		done   = 1'b0;
		tk_inc = tk_a + i2cblm_pkg::tick_t'(1);

		if (ph_a != i2cblm_pkg::PH_IDLE) begin
			scl_n = lvl_scl;
			sda_n = lvl_sda;
			busy  = 1'b1;
			tk_n  = tk_inc;
			if (tk_inc >= h_eff) begin
				// phase over
				tk_n = '0;
				if (ph_a == i2cblm_pkg::PH_FIRST) begin
					ph_n = i2cblm_pkg::PH_SECOND;
				end else if (cmd_a == i2cblm_pkg::CMD_STOP) begin
					if (ph_a == i2cblm_pkg::PH_SECOND) ph_n = i2cblm_pkg::PH_THIRD;
					else done = 1'b1;
				end else if (cmd_a == i2cblm_pkg::CMD_WRITE) begin
					if (bc_a < i2cblm_pkg::BITS_PER_BYTE) begin
						sh_n = {sh_a[6:0], 1'b0};
						bc_n = bc_a + i2cblm_pkg::bit_cnt_t'(1);
						ph_n = i2cblm_pkg::PH_FIRST;
					end else begin
						// ack bit sampled at the end of the ninth scl-high phase
						ack_n = in_sda;
						done  = 1'b1;
					end
				end else if (cmd_a == i2cblm_pkg::CMD_READ) begin
					sh_n = {sh_a[6:0], in_sda};
					bc_n = bc_a + i2cblm_pkg::bit_cnt_t'(1);
					if (bc_n >= i2cblm_pkg::BITS_PER_BYTE) begin
						read_n = sh_n;
						done   = 1'b1;
					end else begin
						ph_n = i2cblm_pkg::PH_FIRST;
					end
				end else begin
					done = 1'b1;
				end
			end
		end

		// levels shown this tick are taken before the end-of-command release
		scl_out = scl_n;
		sda_out = sda_n;

		if (done) begin
			ph_n = i2cblm_pkg::PH_IDLE;
			bc_n = '0;
			// data commands leave scl low
			if (cmd_a != i2cblm_pkg::CMD_START && cmd_a != i2cblm_pkg::CMD_STOP) scl_n = 1'b0;
		end

		res_n.scl_level    = scl_out;
		res_n.sda_level    = sda_out;
		res_n.busy_res     = busy;
		res_n.done_res     = done;
		res_n.read_byte    = read_n;
		res_n.nack_seen    = ack_n;
		res_n.cmd_rejected = rejected;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= i2cblm_pkg::HALF_PHASE_RESET;
		end else if (cfg_wr_en) begin
			half_q <= cfg_wr_data;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2cblm_pkg::PH_IDLE;
			bit_cnt_q <= '0;
			tick_q    <= '0;
			shift_q   <= '0;
			act_cmd_q <= i2cblm_pkg::CMD_NONE;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			ack_q     <= 1'b0;
			read_q    <= '0;
		end else if (accept) begin
			phase_q   <= ph_n;
			bit_cnt_q <= bc_n;
			tick_q    <= tk_n;
			shift_q   <= sh_n;
			act_cmd_q <= cmd_a;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			ack_q     <= ack_n;
			read_q    <= read_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q};

	// done only ever reported on a busy tick
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2])
		else $error("done without busy");

	// an idle sequencer has no bits in flight
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cblm_pkg::PH_IDLE |-> bit_cnt_q == '0)
		else $error("bit count left over while idle");

	// never more than one byte worth of bits
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= i2cblm_pkg::BITS_PER_BYTE)
		else $error("bit count out of range");

	// a rejected command cannot come from an idle sequencer
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == i2cblm_pkg::PH_IDLE |=> !res_q.cmd_rejected)
		else $error("reject flagged while idle");

endmodule
